// File: sv/wsta_pkg.sv
package wsta_pkg;

   // sizing
   localparam int NUM_SERVERS = 16;
   localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

   // field widths
   localparam int SERVER_ID_W = 4;
   localparam int WEIGHT_W = 20;
   localparam int DURATION_W = 20;
   localparam int TIME_W = 40;
   localparam int CSR_W = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [CSR_W-1:0] SERVERS_IN_USE_RESET = CSR_W'(16);

   // request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TASK = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [SERVER_ID_W-1:0] server_id;
      logic [WEIGHT_W-1:0]    weight;
      logic [DURATION_W-1:0]  duration;
   } req_type;

   typedef struct packed {
      logic [SERVER_ID_W-1:0] assigned_server;
      logic [TIME_W-1:0]      start_time;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_weight;
      logic begin_task;
      logic scan_min;
      logic scan_sel;
      logic commit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_index;
   } status_type;

endpackage

// File: sv/wsta_ctrl.sv
module wsta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_operation,
   input  wsta_pkg::status_type status,
   output wsta_pkg::cmd_type    cmd,
   output logic                 busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_MIN,
      ST_SCAN_SEL,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operation == wsta_pkg::OP_TASK) begin
                  cmd.begin_task = 1'b1;
                  state_in = ST_SCAN_MIN;
               end else begin
                  cmd.load_weight = 1'b1;
               end
            end
         end
         ST_SCAN_MIN: begin
            cmd.scan_min = 1'b1;
            if (status.last_index) begin
               state_in = ST_SCAN_SEL;
            end
         end
         ST_SCAN_SEL: begin
            cmd.scan_sel = 1'b1;
            if (status.last_index) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// File: sv/wsta_datapath.sv
module wsta_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wsta_pkg::cmd_type                   cmd,
   input  wsta_pkg::req_type                   req_item,
   input  logic                                csr_write_enable,
   input  logic [wsta_pkg::CSR_W-1:0]          csr_write_data,
   output wsta_pkg::status_type                status,
   output logic                                rsp_strobe,
   output wsta_pkg::rsp_type                   rsp_item
);

   localparam int IDX_W = wsta_pkg::IDX_W;
   localparam int TIME_W = wsta_pkg::TIME_W;
   localparam int WEIGHT_W = wsta_pkg::WEIGHT_W;

   // server tables
   logic [TIME_W-1:0]   free_at_ff [wsta_pkg::NUM_SERVERS];
   logic [WEIGHT_W-1:0] weight_ff [wsta_pkg::NUM_SERVERS];

   // configuration and global time
   logic [wsta_pkg::CSR_W-1:0] servers_in_use_ff;
   logic [TIME_W-1:0]          current_time_ff, current_time_in;
   logic [TIME_W-1:0]          task_count_ff, task_count_in;

   // per task working registers
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [IDX_W-1:0]                last_ff, last_in;
   logic [TIME_W-1:0]               t_ff, t_in;
   logic [wsta_pkg::DURATION_W-1:0] dur_ff, dur_in;
   logic                            any_free_ff, any_free_in;
   logic [TIME_W-1:0]               earliest_ff, earliest_in;
   logic                            found_ff, found_in;
   logic [IDX_W-1:0]                best_ff, best_in;
   logic [WEIGHT_W-1:0]             best_w_ff, best_w_in;

   // result register
   logic                rsp_strobe_ff, rsp_strobe_in;
   wsta_pkg::rsp_type   rsp_item_ff, rsp_item_in;

   logic [TIME_W-1:0]   fa_rd;
   logic [WEIGHT_W-1:0] w_rd;
   logic                fa_le_t;
   logic                take;
   logic                at_last;
   logic [TIME_W:0]     free_sum;
   logic [TIME_W-1:0]   new_free_at;
   logic [IDX_W-1:0]    load_idx;
   logic                load_ok;
   logic [IDX_W-1:0]    clamp_last;

   assign fa_rd = free_at_ff[idx_ff];
   assign w_rd = weight_ff[idx_ff];
   assign fa_le_t = (fa_rd <= t_ff);
   assign take = fa_le_t && (!found_ff || (w_rd < best_w_ff));
   assign at_last = (idx_ff == last_ff);
   assign status.last_index = at_last;

   // saturating finish time
   assign free_sum = {1'b0, t_ff} + (TIME_W + 1)'(dur_ff);
   assign new_free_at = free_sum[TIME_W] ? wsta_pkg::TIME_MAX : free_sum[TIME_W-1:0];

   // load address check
   assign load_idx = IDX_W'(req_item.server_id);
   assign load_ok = (32'(req_item.server_id) < wsta_pkg::NUM_SERVERS);

   // servers in use, clamped to the table size, as a last index
   always_comb begin
      priority if (servers_in_use_ff == '0) begin
         clamp_last = '0;
      end else if (32'(servers_in_use_ff) > wsta_pkg::NUM_SERVERS) begin
         clamp_last = IDX_W'(wsta_pkg::NUM_SERVERS - 1);
      end else begin
         clamp_last = IDX_W'(servers_in_use_ff - 1'b1);
      end
   end

   // scan and commit next values
   always_comb begin
      idx_in = idx_ff;
      last_in = last_ff;
      t_in = t_ff;
      dur_in = dur_ff;
      any_free_in = any_free_ff;
      earliest_in = earliest_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_w_in = best_w_ff;
      current_time_in = current_time_ff;
      task_count_in = task_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in = rsp_item_ff;

      if (cmd.begin_task) begin
         idx_in = '0;
         last_in = clamp_last;
         t_in = (task_count_ff > current_time_ff) ? task_count_ff : current_time_ff;
         dur_in = req_item.duration;
         any_free_in = 1'b0;
         earliest_in = wsta_pkg::TIME_MAX;
         found_in = 1'b0;
         best_in = '0;
         best_w_in = '0;
      end

      // first pass: any server free, earliest free-at time
      if (cmd.scan_min) begin
         any_free_in = any_free_ff | fa_le_t;
         earliest_in = (fa_rd < earliest_ff) ? fa_rd : earliest_ff;
         if (at_last) begin
            idx_in = '0;
            if (!any_free_in) begin
               t_in = earliest_in;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      // second pass: lowest weight among free servers
      if (cmd.scan_sel) begin
         if (take) begin
            found_in = 1'b1;
            best_in = idx_ff;
            best_w_in = w_rd;
         end
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end

      // commit the assignment and emit the result
      if (cmd.commit) begin
         current_time_in = t_ff;
         if (task_count_ff != wsta_pkg::TIME_MAX) begin
            task_count_in = task_count_ff + 1'b1;
         end
         rsp_strobe_in = 1'b1;
         rsp_item_in.assigned_server = wsta_pkg::SERVER_ID_W'(best_ff);
         rsp_item_in.start_time = t_ff;
      end
   end

   // control and time registers
   always_ff @(posedge clock) begin
      if (reset) begin
         servers_in_use_ff <= wsta_pkg::SERVERS_IN_USE_RESET;
         current_time_ff <= '0;
         task_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < wsta_pkg::NUM_SERVERS; i++) begin
            free_at_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            servers_in_use_ff <= csr_write_data;
         end
         current_time_ff <= current_time_in;
         task_count_ff <= task_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.commit) begin
            free_at_ff[best_ff] <= new_free_at;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      last_ff <= last_in;
      t_ff <= t_in;
      dur_ff <= dur_in;
      any_free_ff <= any_free_in;
      earliest_ff <= earliest_in;
      found_ff <= found_in;
      best_ff <= best_in;
      best_w_ff <= best_w_in;
      rsp_item_ff <= rsp_item_in;
   end

   // weight table, undefined until loaded
   always_ff @(posedge clock) begin
      if (cmd.load_weight && load_ok) begin
         weight_ff[load_idx] <= req_item.weight;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

endmodule

// File: sv/weighted_server_task_assigner_top.sv
// Weighted server task assigner. A request with operation load writes one
// server weight and is taken with no result. A task request is latched,
// then a pass over the free-at table of the servers in use finds the
// earliest free time, a pass over the weights makes the choice, and a
// commit follows; each pass reads one table entry per cycle. busy is high
// from the first pass through the commit, and the result shows on rsp_item
// with rsp_strobe for exactly one cycle as busy falls. The receiver cannot
// stall it and must take it in that cycle. Write csr_write_data only while
// busy is low.
module weighted_server_task_assigner_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  wsta_pkg::req_type          req_item,
   output logic                       rsp_strobe,
   output wsta_pkg::rsp_type          rsp_item,
   input  logic                       csr_write_enable,
   input  logic [wsta_pkg::CSR_W-1:0] csr_write_data
);

   wsta_pkg::cmd_type    cmd;
   wsta_pkg::status_type status;

   // sequencing
   wsta_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_item.operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   // tables, scans and result
   wsta_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item)
   );

endmodule
